FILE: sv/pae_pkg.sv
package pae_pkg;

  localparam int POS_W = 6;
  localparam int IDX_W = 6;
  localparam int CNT_W = 6;
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    OP_INSERT       = 3'd0,
    OP_DELETE       = 3'd1,
    OP_SEARCH_ALL   = 3'd2,
    OP_SEARCH_FIRST = 3'd3,
    OP_UPDATE       = 3'd4,
    OP_READ         = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_FINISH,
    S_END
  } fsm_t;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [POS_W-1:0]       position;
    logic signed [VAL_W-1:0] operand_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        found_index;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    last_result;
  } rsp_item_t;

  typedef struct packed {
    logic    load;
    logic    start;
    logic    run;
    logic    wr_item;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_end;
    status_t emit_st;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       pos_gt_cnt;
    logic       pos_ge_cnt;
    logic       out_free;
    logic       busy;
    logic       hit_done;
  } sts_t;

endpackage

FILE: sv/pae_ctrl.sv
module pae_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pae_pkg::sts_t sts,
  output pae_pkg::cmd_t cmd
);

  pae_pkg::fsm_t    state;
  pae_pkg::fsm_t    state_next;
  logic             chk_bad;
  pae_pkg::status_t chk_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    chk_bad  = 1'b0;
    chk_code = pae_pkg::ST_OK;
    case (sts.op)
      pae_pkg::OP_INSERT: begin
        chk_bad  = sts.full || sts.pos_gt_cnt;
        chk_code = sts.full ? pae_pkg::ST_FULL : pae_pkg::ST_RANGE;
      end
      pae_pkg::OP_DELETE, pae_pkg::OP_UPDATE, pae_pkg::OP_READ: begin
        chk_bad  = sts.pos_ge_cnt;
        chk_code = pae_pkg::ST_RANGE;
      end
      pae_pkg::OP_SEARCH_ALL, pae_pkg::OP_SEARCH_FIRST: begin
        chk_bad = 1'b0;
      end
      default: begin
        chk_bad  = 1'b1;
        chk_code = pae_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      pae_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = pae_pkg::S_CHECK;
        end
      end
      pae_pkg::S_CHECK: begin
        if (chk_bad) begin
          if (sts.out_free) begin
            cmd.emit    = 1'b1;
            cmd.emit_st = chk_code;
            state_next  = pae_pkg::S_IDLE;
          end
        end else if (sts.op == pae_pkg::OP_UPDATE) begin
          if (sts.out_free) begin
            cmd.wr_item = 1'b1;
            cmd.emit    = 1'b1;
            cmd.emit_st = pae_pkg::ST_OK;
            state_next  = pae_pkg::S_IDLE;
          end
        end else begin
          cmd.start  = 1'b1;
          state_next = pae_pkg::S_RUN;
        end
      end
      pae_pkg::S_RUN: begin
        cmd.run = 1'b1;
        if (sts.hit_done) begin
          state_next = pae_pkg::S_IDLE;
        end else if (!sts.busy) begin
          if (sts.op == pae_pkg::OP_INSERT || sts.op == pae_pkg::OP_DELETE) begin
            state_next = pae_pkg::S_FINISH;
          end else begin
            state_next = pae_pkg::S_END;
          end
        end
      end
      pae_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = pae_pkg::ST_OK;
          if (sts.op == pae_pkg::OP_INSERT) begin
            cmd.wr_item = 1'b1;
            cmd.cnt_inc = 1'b1;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
          state_next = pae_pkg::S_IDLE;
        end
      end
      pae_pkg::S_END: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_end = 1'b1;
          state_next   = pae_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pae_pkg::S_IDLE;
      end
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("final beat issued while response register is blocked");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == pae_pkg::S_CHECK)
    else $error("accepted request not decoded");

endmodule

FILE: sv/pae_dp.sv
module pae_dp #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pae_pkg::req_item_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output pae_pkg::rsp_item_t rsp_data,
  input  pae_pkg::cmd_t      cmd,
  output pae_pkg::sts_t      sts
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > pae_pkg::POS_W) ? CW : pae_pkg::POS_W;

  logic [pae_pkg::VAL_W-1:0] mem [DEPTH];

  logic [2:0]                op;
  logic [pae_pkg::POS_W-1:0] pos;
  logic [pae_pkg::VAL_W-1:0] val;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_after;
  logic [CW-1:0]             ptr;
  logic [CW-1:0]             left;
  logic                      dn;
  logic                      s1_vld;
  logic [AW-1:0]             s1_idx;
  logic [pae_pkg::VAL_W-1:0] rdata;
  logic                      pend_vld;
  logic [AW-1:0]             pend_idx;

  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             cnt_x;
  logic                      out_free;
  logic                      match;
  logic                      is_shift;
  logic                      need_emit;
  logic                      stall;
  logic                      adv;
  logic                      issue;
  logic                      run_emit;
  logic                      sh_we;
  logic                      we;
  logic [AW-1:0]             wa;
  logic [pae_pkg::VAL_W-1:0] wd;
  logic                      emit_any;
  pae_pkg::rsp_item_t        emit_data;

  assign pos_x    = XW'(pos);
  assign cnt_x    = XW'(cnt);
  assign out_free = !rsp_valid || rsp_ready;
  assign match    = (rdata == val);
  assign is_shift = (op == pae_pkg::OP_INSERT) || (op == pae_pkg::OP_DELETE);

  always_comb begin
    need_emit = 1'b0;
    case (op)
      pae_pkg::OP_READ:         need_emit = 1'b1;
      pae_pkg::OP_SEARCH_FIRST: need_emit = match;
      pae_pkg::OP_SEARCH_ALL:   need_emit = match && pend_vld;
      default:                  need_emit = 1'b0;
    endcase
  end

  assign stall    = s1_vld && need_emit && !out_free;
  assign adv      = cmd.run && !stall;
  assign issue    = adv && (left != '0);
  assign run_emit = adv && s1_vld && need_emit;
  assign sh_we    = adv && s1_vld && is_shift;
  assign we       = sh_we || cmd.wr_item;
  assign wa       = !sh_we ? pos[AW-1:0] :
                    (op == pae_pkg::OP_INSERT) ? s1_idx + AW'(1) : s1_idx - AW'(1);
  assign wd       = sh_we ? rdata : val;
  assign emit_any = run_emit || cmd.emit;

  always_comb begin
    cnt_after = cnt;
    if (cmd.cnt_inc) begin
      cnt_after = cnt + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_after = cnt - CW'(1);
    end
  end

  always_comb begin
    emit_data             = '0;
    emit_data.entry_count = pae_pkg::CNT_W'(cnt_after);
    emit_data.last_result = 1'b1;
    if (run_emit) begin
      emit_data.status = pae_pkg::ST_OK;
      case (op)
        pae_pkg::OP_READ: begin
          emit_data.found_index = pos;
          emit_data.read_value  = rdata;
        end
        pae_pkg::OP_SEARCH_FIRST: begin
          emit_data.found_index = pae_pkg::IDX_W'(s1_idx);
        end
        default: begin
          emit_data.found_index = pae_pkg::IDX_W'(pend_idx);
          emit_data.last_result = 1'b0;
        end
      endcase
    end else if (cmd.emit_end) begin
      emit_data.status      = pend_vld ? pae_pkg::ST_OK : pae_pkg::ST_NOTFOUND;
      emit_data.found_index = pend_vld ? pae_pkg::IDX_W'(pend_idx) : '0;
    end else begin
      emit_data.status      = cmd.emit_st;
      emit_data.found_index = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rdata <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req_data.opcode;
      pos <= req_data.position;
      val <= req_data.operand_value;
    end
    if (emit_any) begin
      rsp_data <= emit_data;
    end
    if (issue) begin
      s1_idx <= ptr[AW-1:0];
    end
    if (adv && s1_vld && match && op == pae_pkg::OP_SEARCH_ALL) begin
      pend_idx <= s1_idx;
    end
    if (cmd.start) begin
      case (op)
        pae_pkg::OP_INSERT: begin
          ptr  <= cnt - CW'(1);
          left <= CW'(cnt_x - pos_x);
          dn   <= 1'b1;
        end
        pae_pkg::OP_DELETE: begin
          ptr  <= CW'(pos_x + XW'(1));
          left <= CW'(cnt_x - pos_x - XW'(1));
          dn   <= 1'b0;
        end
        pae_pkg::OP_READ: begin
          ptr  <= CW'(pos_x);
          left <= CW'(1);
          dn   <= 1'b0;
        end
        default: begin
          ptr  <= '0;
          left <= cnt;
          dn   <= 1'b0;
        end
      endcase
    end else if (issue) begin
      ptr  <= dn ? ptr - CW'(1) : ptr + CW'(1);
      left <= left - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
      s1_vld    <= 1'b0;
      pend_vld  <= 1'b0;
    end else begin
      cnt <= cnt_after;
      if (emit_any) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.start) begin
        s1_vld   <= 1'b0;
        pend_vld <= 1'b0;
      end else begin
        if (adv) begin
          s1_vld <= issue;
        end
        if (adv && s1_vld && match && op == pae_pkg::OP_SEARCH_ALL) begin
          pend_vld <= 1'b1;
        end
      end
    end
  end

  assign sts.op         = op;
  assign sts.full       = (cnt == CW'(DEPTH));
  assign sts.pos_gt_cnt = (pos_x > cnt_x);
  assign sts.pos_ge_cnt = (pos_x >= cnt_x);
  assign sts.out_free   = out_free;
  assign sts.busy       = (left != '0) || s1_vld;
  assign sts.hit_done   = run_emit && (op != pae_pkg::OP_SEARCH_ALL);

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    we |-> (XW'(wa) <= cnt_x))
    else $error("write lands past the list end");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !emit_any)
    else $error("response beat overwritten before taken");

endmodule

FILE: sv/positional_array_engine.sv
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req_data  (opcode, position, operand_value)
// response| rsp_valid | rsp_ready | rsp_data  (status, found_index, read_value,
//         |           |           |            entry_count, last_result)
// Update, spare opcodes and refused items finish from the check state; read, insert,
//   delete and searches run through the entry store, one memory read a cycle while no
//   stalled response holds it; a search first that hits ends on its matching index.
// One item at a time; the next is taken once the last beat is in the response register.
// Reset clears the count and control; entries are meaningless until written.
// A stalled response holds a read or search at its next beat and holds every final beat.
module positional_array_engine #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  pae_pkg::req_item_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output pae_pkg::rsp_item_t rsp_data
);

  pae_pkg::cmd_t cmd;
  pae_pkg::sts_t sts;

  pae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pae_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
